@@ rtl/adb_pkg.sv @@
// Shared constants and types for the ADC deadband BCD framer.
`default_nettype none
package adb_pkg;

	// Default width of the filter datapath.
	localparam int unsigned SAMPLE_BITS_DEF = 10;

	// Fixed field widths of the stream and configuration ports.
	localparam int unsigned SAMPLE_W     = 10;
	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned FILT_W       = 10;
	localparam int unsigned IN_TDATA_W   = 16;
	localparam int unsigned OUT_TDATA_W  = 24;
	localparam int unsigned CFG_DATA_W   = 10;
	localparam int unsigned CFG_INDEX_W  = 2;

	// Frame delimiters.
	localparam logic [BYTE_W-1:0] OPEN_BYTE  = 8'h28;
	localparam logic [BYTE_W-1:0] CLOSE_BYTE = 8'h29;

	// Register reset values.
	localparam logic [7:0] BASE_DB_RST      = 8'd10;
	localparam logic [7:0] UPPER_DB_RST     = 8'd15;
	localparam logic [9:0] REGION_START_RST = 10'd900;
	localparam logic [7:0] END_MARGIN_RST   = 8'd3;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BASE_DB      = 2'd0,
		REG_UPPER_DB     = 2'd1,
		REG_REGION_START = 2'd2,
		REG_END_MARGIN   = 2'd3
	} reg_index_t;

	// Current register contents, handed to the filter.
	typedef struct packed {
		logic [7:0] base_deadband;
		logic [7:0] upper_deadband;
		logic [9:0] upper_region_start;
		logic [7:0] end_margin;
	} cfg_t;

endpackage
`default_nettype wire

@@ rtl/adb_front.sv @@
// Front end: sample register, deadband filter, end snapping and history.
`default_nettype none
module adb_front #(
	parameter int unsigned SAMPLE_BITS = adb_pkg::SAMPLE_BITS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [adb_pkg::SAMPLE_W-1:0]  sample,
	input  wire  adb_pkg::cfg_t           cfg,
	output logic                          push_valid,
	input  wire                           push_ready,
	output logic [SAMPLE_BITS-1:0]        push_data
);
	import adb_pkg::*;

	// Compare width: holds the value plus deadband plus margin without overflow.
	localparam int unsigned XW = ((SAMPLE_BITS > FILT_W) ? SAMPLE_BITS : FILT_W) + 2;

	logic                   s1_valid_q;
	logic [SAMPLE_BITS-1:0] raw_s1;
	logic [FILT_W-1:0]      prev_q;

	logic [XW-1:0] raw_x, prev_x, db_x, diff_x, keep_x, lo_x, fs_x, res_x;

	assign fs_x = {{(XW-SAMPLE_BITS){1'b0}}, {SAMPLE_BITS{1'b1}}};

	always_comb begin
		raw_x  = XW'(raw_s1);
		prev_x = XW'(prev_q);
		db_x   = (raw_x > XW'(cfg.upper_region_start)) ? XW'(cfg.upper_deadband)
		                                               : XW'(cfg.base_deadband);
		diff_x = (raw_x >= prev_x) ? (raw_x - prev_x) : (prev_x - raw_x);
		keep_x = (diff_x <= db_x) ? prev_x : raw_x;
		lo_x   = db_x + XW'(cfg.end_margin);
		// Snapping to zero wins over snapping to full scale.
		priority if (keep_x < lo_x) begin
			res_x = '0;
		end else if (keep_x + lo_x >= fs_x) begin
			res_x = fs_x;
		end else begin
			res_x = keep_x;
		end
	end

	assign push_valid = s1_valid_q;
	assign push_data  = SAMPLE_BITS'(res_x);
	assign s_tready   = !s1_valid_q || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			prev_q     <= '0;
		end else begin
			if (s1_valid_q && push_ready) begin
				prev_q <= FILT_W'(res_x);
			end
			if (s_tready) begin
				s1_valid_q <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			raw_s1 <= SAMPLE_BITS'(sample);
		end
	end

endmodule
`default_nettype wire

@@ rtl/adb_fifo.sv @@
// Small register queue between the filter and the frame emitter.
`default_nettype none
module adb_fifo #(
	parameter int unsigned WIDTH = 10,
	parameter int unsigned DEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	output logic             push_ready,
	input  wire  [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  wire              pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ rtl/adb_back.sv @@
// Back end: splits a value into decimal digits and emits the six-beat frame.
`default_nettype none
module adb_back #(
	parameter int unsigned SAMPLE_BITS = adb_pkg::SAMPLE_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              pop_valid,
	output logic                             pop_ready,
	input  wire  [SAMPLE_BITS-1:0]           pop_data,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [adb_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                             m_tlast
);
	import adb_pkg::*;

	// x / 10 == (x * 52429) >> 19 holds exactly for every x below 81920.
	localparam int unsigned    MW        = SAMPLE_BITS + 17;
	localparam logic [16:0]    RECIP10   = 17'd52429;
	localparam logic [2:0]     LAST_BEAT = 3'd5;

	logic                   active_q;
	logic [2:0]             cnt_q;
	logic [SAMPLE_BITS-1:0] rem_q;
	logic [FILT_W-1:0]      val_q;
	logic [BYTE_W-1:0]      byte_q;
	logic                   adv;
	logic [MW-1:0]          prod;
	logic [SAMPLE_BITS-1:0] quo, quo_x10;
	logic [3:0]             digit;

	assign prod    = MW'(rem_q) * MW'(RECIP10);
	assign quo     = SAMPLE_BITS'(prod >> 19);
	assign quo_x10 = SAMPLE_BITS'({quo, 3'b000}) + SAMPLE_BITS'({quo, 1'b0});
	assign digit   = 4'(rem_q - quo_x10);

	assign adv       = !m_tvalid || m_tready;
	assign pop_ready = adv && !active_q;
	assign m_tdata   = {{(OUT_TDATA_W - FILT_W - BYTE_W){1'b0}}, val_q, byte_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
			m_tlast  <= 1'b0;
		end else if (adv) begin
			if (active_q) begin
				m_tvalid <= 1'b1;
				m_tlast  <= (cnt_q == LAST_BEAT);
				cnt_q    <= cnt_q + 1'b1;
				if (cnt_q == LAST_BEAT) begin
					active_q <= 1'b0;
				end
			end else if (pop_valid) begin
				m_tvalid <= 1'b1;
				m_tlast  <= 1'b0;
				cnt_q    <= 3'd1;
				active_q <= 1'b1;
			end else begin
				m_tvalid <= 1'b0;
				m_tlast  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (active_q) begin
				byte_q <= (cnt_q == LAST_BEAT) ? CLOSE_BYTE : {4'b0000, digit};
				rem_q  <= quo;
			end else if (pop_valid) begin
				byte_q <= OPEN_BYTE;
				rem_q  <= pop_data;
				val_q  <= FILT_W'(pop_data);
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/adc_deadband_bcd_framer.sv @@
// Top level of the ADC deadband filter and decimal frame generator.
//
//  Channel  Direction  Signals                        Beat contents
//  s_*      in         s_tvalid s_tready s_tdata      tdata[9:0] sample
//  m_*      out        m_tvalid m_tready m_tdata      tdata[7:0] tx_byte,
//                      m_tlast                        tdata[17:8] filtered_value,
//                                                     tlast frame_end
//  cfg_*    in         cfg_we cfg_index cfg_wdata     register write, no read-back
//
// Every sample produces six output beats, one per cycle while m_tready holds,
// so the frame emitter's output register sets the sustained sample rate; it
// takes the next sample once its closing beat is accepted. A sample passes the
// input stage and queue into the output register. Reset clears the previous
// output, the queue and the configuration registers to their defaults. The
// input side keeps accepting while the two-entry queue has room, so a stalled
// output only backs up the input once the queue and the input stage are full.
`default_nettype none
module adc_deadband_bcd_framer #(
	parameter int unsigned SAMPLE_BITS = adb_pkg::SAMPLE_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// Input stream. tdata fields from bit 0: sample[9:0], zero padding.
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [adb_pkg::IN_TDATA_W-1:0]   s_tdata,
	// Output stream. tdata fields from bit 0: tx_byte[7:0],
	// filtered_value[9:0], zero padding. tlast marks the closing byte.
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [adb_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                             m_tlast,
	// Configuration write port.
	input  wire                              cfg_we,
	input  wire  [adb_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire  [adb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import adb_pkg::*;

	cfg_t                   cfg_q;
	logic                   push_valid, push_ready;
	logic [SAMPLE_BITS-1:0] push_data;
	logic                   pop_valid, pop_ready;
	logic [SAMPLE_BITS-1:0] pop_data;

	// Configuration registers. The index space is fully decoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_deadband      <= BASE_DB_RST;
			cfg_q.upper_deadband     <= UPPER_DB_RST;
			cfg_q.upper_region_start <= REGION_START_RST;
			cfg_q.end_margin         <= END_MARGIN_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_BASE_DB:      cfg_q.base_deadband      <= cfg_wdata[7:0];
				REG_UPPER_DB:     cfg_q.upper_deadband     <= cfg_wdata[7:0];
				REG_REGION_START: cfg_q.upper_region_start <= cfg_wdata[9:0];
				REG_END_MARGIN:   cfg_q.end_margin         <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// While the queue has room, the front end filters one sample per cycle and
	// owns the history, so samples see prior results without waiting on output.
	adb_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.sample     (s_tdata[SAMPLE_W-1:0]),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	adb_fifo #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (2)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// The back end peels off one decimal digit per beat while it sends.
	adb_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// The closing beat always carries the closing delimiter.
	a_close_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[BYTE_W-1:0] == CLOSE_BYTE)
		else $error("closing beat without closing delimiter");

	// Digit beats carry a decimal digit.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast && m_tdata[BYTE_W-1:0] != OPEN_BYTE
		|-> m_tdata[BYTE_W-1:0] <= 8'd9)
		else $error("digit beat out of range");

	// Within a frame the next beat follows at once with the same value.
	a_frame_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast
		|=> m_tvalid && $stable(m_tdata[BYTE_W+FILT_W-1:BYTE_W]))
		else $error("frame value changed mid-frame");

	// An opening delimiter never ends a frame.
	a_open_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[BYTE_W-1:0] == OPEN_BYTE |-> !m_tlast)
		else $error("opening delimiter flagged as last beat");

endmodule
`default_nettype wire

@@ sim/tb_adc_deadband_bcd_framer.sv @@
// Self-checking testbench for the ADC deadband filter and decimal frame generator.
`default_nettype none
module tb_adc_deadband_bcd_framer;
	timeunit 1ns;
	timeprecision 1ps;

	import adb_pkg::*;

	// Full scale of the 10-bit filter datapath.
	localparam int FULL_SCALE = (1 << SAMPLE_W) - 1;
	// Cycles without any beat on either stream before the run is declared hung.
	localparam int QUIET_LIMIT = 1000;
	// Only the first few mismatches are printed in detail.
	localparam int REPORT_LIMIT = 10;

	// One row of the directed table is either a sample beat or a register write.
	typedef enum logic {
		ROW_SAMPLE,
		ROW_WRITE
	} row_kind_t;

	// For sample rows, "pinned" says the filtered value is typed in the table;
	// otherwise the predictor supplies it. For write rows, "which" and "data" apply.
	typedef struct packed {
		row_kind_t  kind;
		reg_index_t which;
		logic [9:0] data;
		logic       pinned;
		logic [9:0] result;
	} row_t;

	// A filtered value that the table fixes for one sample, or none.
	typedef struct {
		bit         pinned;
		logic [9:0] result;
	} pinned_value_t;

	// One expected output beat.
	typedef struct {
		logic [BYTE_W-1:0] tx_byte;
		logic [FILT_W-1:0] value;
		logic              last;
	} frame_beat_t;

	// Directed part. It starts from the reset settings and walks through the
	// corners of the deadband and snapping logic, then repeats with all
	// registers at zero (no filtering, no snapping) and at their maximum.
	localparam row_t DIRECTED_ROWS [31] = '{
		// Reset settings: deadband 10 (15 above 900), margin 3.
		'{ROW_SAMPLE, REG_BASE_DB,      10'd0,    1'b1, 10'd0},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd1023, 1'b1, 10'd1023},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd1008, 1'b1, 10'd1023},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd1007, 1'b1, 10'd1023},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd900,  1'b1, 10'd900},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd910,  1'b0, 10'd0},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd12,   1'b1, 10'd0},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd13,   1'b1, 10'd13},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd999,  1'b1, 10'd999},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd1009, 1'b0, 10'd0},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd512,  1'b1, 10'd512},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd341,  1'b1, 10'd341},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd682,  1'b1, 10'd682},
		// Everything at zero: the output follows the sample exactly.
		'{ROW_WRITE,  REG_BASE_DB,      10'd0,    1'b0, 10'd0},
		'{ROW_WRITE,  REG_UPPER_DB,     10'd0,    1'b0, 10'd0},
		'{ROW_WRITE,  REG_REGION_START, 10'd0,    1'b0, 10'd0},
		'{ROW_WRITE,  REG_END_MARGIN,   10'd0,    1'b0, 10'd0},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd682,  1'b1, 10'd682},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd0,    1'b1, 10'd0},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd1,    1'b1, 10'd1},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd1023, 1'b1, 10'd1023},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd1022, 1'b1, 10'd1022},
		// Everything at maximum: only 510..512 survive without snapping.
		'{ROW_WRITE,  REG_BASE_DB,      10'd255,  1'b0, 10'd0},
		'{ROW_WRITE,  REG_UPPER_DB,     10'd255,  1'b0, 10'd0},
		'{ROW_WRITE,  REG_REGION_START, 10'd1023, 1'b0, 10'd0},
		'{ROW_WRITE,  REG_END_MARGIN,   10'd255,  1'b0, 10'd0},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd768,  1'b0, 10'd0},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd511,  1'b1, 10'd511},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd509,  1'b0, 10'd0},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd0,    1'b1, 10'd0},
		'{ROW_SAMPLE, REG_BASE_DB,      10'd512,  1'b1, 10'd512}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // sample[9:0], zero padding
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // tx_byte[7:0], filtered_value[17:8], zero padding
	logic                   m_tlast;   // frame_end
	logic                   cfg_we;
	reg_index_t             cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	// Predictor state: its own copy of the registers and of the last output.
	logic [7:0] base_db;
	logic [7:0] upper_db;
	logic [9:0] region_start;
	logic [7:0] margin;
	logic [9:0] last_value;

	// Filtered values fixed by the table, one per sample in flight to the block.
	pinned_value_t pinned_q[$];
	// Output beats still owed by the block, oldest first.
	frame_beat_t   owed_beats_q[$];
	// Copy of the owed-beat count, updated at the clock edge so that the
	// stimulus process reads a settled value.
	int            owed_count;

	int  mismatches;
	int  quiet_cycles;
	bit  sender_calm;
	bit  sink_calm;

	adc_deadband_bcd_framer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Deadband filter followed by end snapping, as the block should compute it.
	// The deadband choice depends on the raw sample, not on the stored value.
	// Snapping to zero is tested first and so wins over snapping to full scale.
	function automatic logic [9:0] filter_and_snap(logic [9:0] raw);
		int band;
		int distance;
		int level;
		int hi_level;
		band = (raw > region_start) ? int'(upper_db) : int'(base_db);
		distance = (raw >= last_value) ? int'(raw) - int'(last_value)
		                               : int'(last_value) - int'(raw);
		level = (distance <= band) ? int'(last_value) : int'(raw);
		hi_level = FULL_SCALE - band - int'(margin);
		if (level < band + int'(margin))
			level = 0;
		else if (level >= hi_level)
			level = FULL_SCALE;
		return level[9:0];
	endfunction

	// Queue the six beats of one frame: open, ones, tens, hundreds, thousands, close.
	task automatic owe_frame(logic [9:0] value);
		int n;
		frame_beat_t beat;
		n = value;
		beat.value = value;
		beat.last = 1'b0;
		beat.tx_byte = OPEN_BYTE;
		owed_beats_q.push_back(beat);
		for (int k = 0; k < 4; k++) begin
			beat.tx_byte = 8'(n % 10);
			owed_beats_q.push_back(beat);
			n = n / 10;
		end
		beat.tx_byte = CLOSE_BYTE;
		beat.last = 1'b1;
		owed_beats_q.push_back(beat);
	endtask

	// Sample choice for the random part. Nearly half land close to the last
	// output, so that the keep-previous path and its edge at exactly the
	// deadband get hit often; the rest sit near the two ends or anywhere.
	function automatic logic [9:0] next_sample();
		int pick;
		int spread;
		int level;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			spread = int'(base_db > upper_db ? base_db : upper_db) + 2;
			level = int'(last_value) + $urandom_range(0, 2 * spread) - spread;
			if (level < 0)
				level = 0;
			if (level > FULL_SCALE)
				level = FULL_SCALE;
		end else if (pick < 60) begin
			level = $urandom_range(0, 40);
		end else if (pick < 75) begin
			level = $urandom_range(FULL_SCALE - 40, FULL_SCALE);
		end else begin
			level = $urandom_range(0, FULL_SCALE);
		end
		return level[9:0];
	endfunction

	// Offer one sample beat after a random gap. The valid stays high on
	// return; the next call or drain_frames decides whether it drops.
	task automatic send_sample(logic [9:0] sample, bit pinned, logic [9:0] result);
		int gap;
		pinned_value_t entry;
		if ($urandom_range(0, 15) == 0)
			sender_calm = !sender_calm;
		gap = sender_calm ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		entry.pinned = pinned;
		entry.result = result;
		pinned_q.push_back(entry);
		s_tdata <= IN_TDATA_W'(sample);
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering samples and wait until every owed beat has come out.
	// Each sample produces a frame, so an empty list means the block is idle.
	task automatic drain_frames();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (owed_count != 0);
	endtask

	// Register write, only ever issued with the block idle.
	task automatic write_reg(reg_index_t which, logic [9:0] data);
		drain_frames();
		cfg_index <= which;
		cfg_wdata <= data;
		cfg_we <= 1'b1;
		case (which)
			REG_BASE_DB:      base_db = data[7:0];
			REG_UPPER_DB:     upper_db = data[7:0];
			REG_REGION_START: region_start = data;
			REG_END_MARGIN:   margin = data[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [9:0] b, logic [9:0] u, logic [9:0] r, logic [9:0] m);
		write_reg(REG_BASE_DB, b);
		write_reg(REG_UPPER_DB, u);
		write_reg(REG_REGION_START, r);
		write_reg(REG_END_MARGIN, m);
	endtask

	task automatic send_random(int count);
		for (int i = 0; i < count; i++)
			send_sample(next_sample(), 1'b0, 10'd0);
	endtask

	// Monitor: predicts a frame for every accepted sample beat and checks every
	// accepted output beat against the oldest owed beat. It also runs the
	// watchdog that ends a hung run.
	always @(posedge clk) begin : monitor
		bit moved;
		logic [9:0] value;
		pinned_value_t entry;
		frame_beat_t want;
		if (arst_n) begin
			moved = 1'b0;
			if (s_tvalid && s_tready) begin
				moved = 1'b1;
				value = filter_and_snap(s_tdata[SAMPLE_W-1:0]);
				if (pinned_q.size() != 0) begin
					entry = pinned_q.pop_front();
					if (entry.pinned)
						value = entry.result;
				end
				last_value = value;
				owe_frame(value);
			end
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				if (owed_beats_q.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: unexpected beat byte=%0d value=%0d last=%0b",
							$realtime, m_tdata[7:0], m_tdata[17:8], m_tlast);
				end else begin
					want = owed_beats_q.pop_front();
					if (m_tdata[7:0] !== want.tx_byte || m_tdata[17:8] !== want.value
						|| m_tlast !== want.last) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%0t: beat mismatch, expected byte=%0d value=%0d last=%0b,%s",
								$realtime, want.tx_byte, want.value, want.last,
								$sformatf(" got byte=%0d value=%0d last=%0b",
									m_tdata[7:0], m_tdata[17:8], m_tlast));
					end
				end
			end
			owed_count <= owed_beats_q.size();
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d beats still owed",
					$realtime, QUIET_LIMIT, owed_beats_q.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Output side: before each beat, hold tready low for a random number of
	// cycles, with calm stretches where it stays high throughout.
	initial begin : sink
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				sink_calm = !sink_calm;
			gap = sink_calm ? 0 : $urandom_range(0, 12);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Main sequence: reset, directed table, then three random phases with
	// different register settings.
	initial begin : stimulus
		row_t row;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BASE_DB;
		cfg_wdata = '0;
		base_db = BASE_DB_RST;
		upper_db = UPPER_DB_RST;
		region_start = REGION_START_RST;
		margin = END_MARGIN_RST;
		last_value = '0;
		owed_count = 0;
		mismatches = 0;
		quiet_cycles = 0;
		sender_calm = 1'b0;
		sink_calm = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			row = DIRECTED_ROWS[i];
			if (row.kind == ROW_WRITE)
				write_reg(row.which, row.data);
			else
				send_sample(row.data, row.pinned, row.result);
		end

		// Narrow deadbands with a random region boundary. Halfway through, the
		// sender holds off until the block has emptied completely.
		write_all(10'($urandom_range(0, 40)), 10'($urandom_range(0, 40)),
			10'($urandom_range(0, FULL_SCALE)), 10'($urandom_range(0, 20)));
		send_random(35);
		drain_frames();
		send_random(35);

		// Any register value at all.
		write_all(10'($urandom_range(0, 255)), 10'($urandom_range(0, 255)),
			10'($urandom_range(0, FULL_SCALE)), 10'($urandom_range(0, 255)));
		send_random(60);

		// Back to the reset settings, written explicitly.
		write_all(10'(BASE_DB_RST), 10'(UPPER_DB_RST), REGION_START_RST,
			10'(END_MARGIN_RST));
		send_random(70);

		// Let the last frame out, then watch a little longer for stray beats.
		drain_frames();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && owed_beats_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

@@ files.f @@
rtl/adb_pkg.sv
rtl/adb_front.sv
rtl/adb_fifo.sv
rtl/adb_back.sv
rtl/adc_deadband_bcd_framer.sv
sim/tb_adc_deadband_bcd_framer.sv
